FILE: design/tiled_rect_quad_generator_macros.svh
// Assertion macros for the tiled rectangle quad generator.
// Used by the RTL file that carries concurrent assertions (tqg_back); depends on nothing.
`ifndef TILED_RECT_QUAD_GENERATOR_MACROS_SVH
`define TILED_RECT_QUAD_GENERATOR_MACROS_SVH
`ifndef ASSERT_OFF
`define TQG_ASSERT_IMPL(label, a, b) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (a) |-> (b)) \
        else $error("assertion failed");
`define TQG_ASSERT_NEXT(label, a, b) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (a) |=> (b)) \
        else $error("assertion failed");
`else
`define TQG_ASSERT_IMPL(label, a, b)
`define TQG_ASSERT_NEXT(label, a, b)
`endif
`endif

FILE: design/tqg_pkg.sv
// Shared types, constants and helper functions of the tiled quad generator.
// Depends on nothing; imported by every module of the block.
`default_nettype none
package tqg_pkg;

    localparam int MAX_TILES  = 64;
    localparam int CNT_W      = (MAX_TILES > 1) ? $clog2(MAX_TILES) : 1;
    localparam int DIV_CYCLES = 20;
    localparam int DIV_CNT_W  = $clog2(DIV_CYCLES);
    localparam int NDC_BIAS   = 16384;
    localparam int NDC_MAX    = 131071;
    localparam int NDC_MIN    = -131072;

    localparam logic [1:0] REG_HALF_WIDTH  = 2'd0;
    localparam logic [1:0] REG_HALF_HEIGHT = 2'd1;
    localparam logic [1:0] REG_TINT        = 2'd2;

    typedef enum logic [2:0] {
        F_IDLE, F_MOD_GO, F_MOD_WAIT, F_TEX_GO, F_TEX_WAIT, F_PUSH
    } front_state_t;

    typedef enum logic [1:0] {
        B_IDLE, B_GO, B_WAIT, B_EMIT
    } back_state_t;

    typedef struct packed {
        logic signed [19:0] x;
        logic signed [19:0] y;
        logic [19:0]        w;
        logic [19:0]        h;
        logic [19:0]        sw;
        logic [19:0]        sh;
        logic [15:0]        us;
        logic [15:0]        vs;
        logic [15:0]        ue;
        logic [15:0]        ve;
        logic [17:0]        u1c;
        logic [17:0]        v1c;
    } desc_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

    // Returns the sign and magnitude of 2048*p + h.
    function automatic logic [40:0] ndc_num(logic signed [21:0] p, logic [15:0] h);
        logic signed [34:0] n;
        logic signed [34:0] m;
        n = ($signed({{13{p[21]}}, p}) <<< 11) + $signed({19'b0, h});
        m = n[34] ? -n : n;
        return {n[34], 6'b0, m[33:0]};
    endfunction

    // Floor correction, bias removal and saturation of a device coordinate.
    function automatic logic [17:0] ndc_fix(logic neg, logic [39:0] q, logic rnz);
        logic signed [41:0] qs;
        logic signed [41:0] r;
        qs = neg ? (-$signed({2'b0, q}) - $signed({41'b0, rnz})) : $signed({2'b0, q});
        r  = qs - 42'(NDC_BIAS);
        if (r > 42'(NDC_MAX)) begin
            return 18'(NDC_MAX);
        end else if (r < 42'(NDC_MIN)) begin
            return 18'(NDC_MIN);
        end
        return r[17:0];
    endfunction

    function automatic logic [19:0] half_den(logic [15:0] half);
        logic [15:0] h;
        h = (half == 16'd0) ? 16'd1 : half;
        return {3'b0, h, 1'b0};
    endfunction

endpackage
`default_nettype wire

FILE: design/tiled_rect_quad_generator.sv
// Top level of the tiled rectangle quad generator: configuration registers,
// front end, descriptor queue and tile walker. Depends on tqg_pkg and submodules.
//
//   port group   direction   beat
//   s_*          in          one rectangle with texture window and tile size
//   m_*          out         one quad per tile, last_tile on the final one
//   cfg_*        in          register write, no handshake
//
// The front end runs two divider passes per rectangle (last-tile remainder, then
// clipped texture scale) and overlaps with the walker. Each quad waits on the
// corner divisions of the walker; each rectangle also needs one pop of its
// descriptor from the queue.
// Empty rectangles are accepted and dropped. Reset is synchronous, active low.
// A stalled result beat does not stop the next tile's division.
`default_nettype none
module tiled_rect_quad_generator (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               cfg_wr_en,
    input  wire logic [1:0]         cfg_index,
    input  wire logic [31:0]        cfg_wr_data,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic signed [19:0] s_rect_x,
    input  wire logic signed [19:0] s_rect_y,
    input  wire logic [19:0]        s_rect_w,
    input  wire logic [19:0]        s_rect_h,
    input  wire logic [15:0]        s_u_start,
    input  wire logic [15:0]        s_v_start,
    input  wire logic [15:0]        s_u_end,
    input  wire logic [15:0]        s_v_end,
    input  wire logic [19:0]        s_tile_w,
    input  wire logic [19:0]        s_tile_h,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic signed [17:0]      m_quad_x0,
    output logic signed [17:0]      m_quad_y0,
    output logic signed [17:0]      m_quad_x1,
    output logic signed [17:0]      m_quad_y1,
    output logic [15:0]             m_tex_u0,
    output logic [15:0]             m_tex_v0,
    output logic signed [17:0]      m_tex_u1,
    output logic signed [17:0]      m_tex_v1,
    output logic [31:0]             m_quad_tint,
    output logic                    m_last_tile,
    output logic                    m_truncated
);
    import tqg_pkg::*;

    logic [15:0] half_w_reg, half_h_reg;
    logic [31:0] tint_reg;
    q_stat_t     q_stat;
    desc_t       q_wr_data, q_rd_data;
    logic        q_push, q_pop;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            half_w_reg <= 16'd1;
            half_h_reg <= 16'd1;
            tint_reg   <= 32'hFFFF_FFFF;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_HALF_WIDTH:  half_w_reg <= cfg_wr_data[15:0];
                REG_HALF_HEIGHT: half_h_reg <= cfg_wr_data[15:0];
                REG_TINT:        tint_reg   <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    tqg_front u_front (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_rect_x(s_rect_x), .s_rect_y(s_rect_y),
        .s_rect_w(s_rect_w), .s_rect_h(s_rect_h),
        .s_u_start(s_u_start), .s_v_start(s_v_start),
        .s_u_end(s_u_end), .s_v_end(s_v_end),
        .s_tile_w(s_tile_w), .s_tile_h(s_tile_h),
        .q_stat(q_stat), .q_push(q_push), .q_data(q_wr_data)
    );

    tqg_queue u_queue (
        .aclk(aclk), .aresetn(aresetn),
        .push(q_push), .wr_data(q_wr_data),
        .pop(q_pop), .rd_data(q_rd_data), .stat(q_stat)
    );

    tqg_back u_back (
        .aclk(aclk), .aresetn(aresetn),
        .q_stat(q_stat), .q_data(q_rd_data), .q_pop(q_pop),
        .half_width(half_w_reg), .half_height(half_h_reg), .tint(tint_reg),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_quad_x0(m_quad_x0), .m_quad_y0(m_quad_y0),
        .m_quad_x1(m_quad_x1), .m_quad_y1(m_quad_y1),
        .m_tex_u0(m_tex_u0), .m_tex_v0(m_tex_v0),
        .m_tex_u1(m_tex_u1), .m_tex_v1(m_tex_v1),
        .m_quad_tint(m_quad_tint), .m_last_tile(m_last_tile),
        .m_truncated(m_truncated)
    );
endmodule
`default_nettype wire

FILE: design/tqg_div.sv
// Radix-4 restoring divider, two quotient bits per cycle, 40-bit dividend.
// Depends on tqg_pkg for its cycle count.
`default_nettype none
module tqg_div (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        start,
    input  wire logic [39:0] num,
    input  wire logic [19:0] den,
    output logic             done,
    output logic [39:0]      quo,
    output logic [19:0]      rem
);
    import tqg_pkg::*;

    logic [39:0]          quo_reg;
    logic [19:0]          rem_reg;
    logic [19:0]          den_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic                 busy_reg;
    logic                 done_reg;
    logic [20:0]          r1, s1, r2, s2;
    logic                 ge1, ge2;

    always_comb begin
        r1  = {rem_reg, quo_reg[39]};
        ge1 = r1 >= {1'b0, den_reg};
        s1  = ge1 ? (r1 - {1'b0, den_reg}) : r1;
        r2  = {s1[19:0], quo_reg[38]};
        ge2 = r2 >= {1'b0, den_reg};
        s2  = ge2 ? (r2 - {1'b0, den_reg}) : r2;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == DIV_CNT_W'(DIV_CYCLES - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            quo_reg <= num;
            rem_reg <= '0;
            den_reg <= den;
        end else if (busy_reg) begin
            quo_reg <= {quo_reg[37:0], ge1, ge2};
            rem_reg <= s2[19:0];
        end
    end

    assign done = done_reg;
    assign quo  = quo_reg;
    assign rem  = rem_reg;
endmodule
`default_nettype wire

FILE: design/tqg_front.sv
// Front end: accepts rectangles, drops empty ones and works out the clipped
// texture coordinates of the last column and row. Depends on tqg_pkg, tqg_div.
`default_nettype none
module tqg_front (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic signed [19:0] s_rect_x,
    input  wire logic signed [19:0] s_rect_y,
    input  wire logic [19:0]        s_rect_w,
    input  wire logic [19:0]        s_rect_h,
    input  wire logic [15:0]        s_u_start,
    input  wire logic [15:0]        s_v_start,
    input  wire logic [15:0]        s_u_end,
    input  wire logic [15:0]        s_v_end,
    input  wire logic [19:0]        s_tile_w,
    input  wire logic [19:0]        s_tile_h,
    input  wire tqg_pkg::q_stat_t   q_stat,
    output logic                    q_push,
    output tqg_pkg::desc_t          q_data
);
    import tqg_pkg::*;

    front_state_t       state_reg, state_next;
    desc_t              d_reg;
    logic signed [37:0] prod_u_reg, prod_v_reg;
    logic               start_mod, start_tex, accept, empty_item;
    logic [39:0]        num_u, num_v;
    logic [19:0]        den_u, den_v;
    logic               done_u, done_v;
    logic [39:0]        quo_u, quo_v;
    logic [19:0]        rem_u, rem_v;
    logic signed [16:0] diff_u, diff_v;
    logic signed [37:0] mag_u, mag_v;
    logic signed [18:0] u1_sum, v1_sum;

    assign accept     = s_valid && s_ready;
    assign empty_item = (s_rect_w == 20'd0) || (s_rect_h == 20'd0) ||
                        (s_tile_w == 20'd0) || (s_tile_h == 20'd0);

    always_comb begin
        state_next = state_reg;
        s_ready    = 1'b0;
        start_mod  = 1'b0;
        start_tex  = 1'b0;
        q_push     = 1'b0;
        case (state_reg)
            F_IDLE: begin
                s_ready = 1'b1;
                if (s_valid && !empty_item) begin
                    state_next = F_MOD_GO;
                end
            end
            F_MOD_GO: begin
                start_mod  = 1'b1;
                state_next = F_MOD_WAIT;
            end
            F_MOD_WAIT: begin
                if (done_u && done_v) begin
                    state_next = F_TEX_GO;
                end
            end
            F_TEX_GO: begin
                start_tex  = 1'b1;
                state_next = F_TEX_WAIT;
            end
            F_TEX_WAIT: begin
                if (done_u && done_v) begin
                    state_next = F_PUSH;
                end
            end
            F_PUSH: begin
                if (!q_stat.full) begin
                    q_push     = 1'b1;
                    state_next = F_IDLE;
                end
            end
            default: state_next = F_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= F_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign mag_u = prod_u_reg[37] ? -prod_u_reg : prod_u_reg;
    assign mag_v = prod_v_reg[37] ? -prod_v_reg : prod_v_reg;
    assign num_u = start_tex ? {2'b0, mag_u} : {20'b0, d_reg.w - 20'd1};
    assign num_v = start_tex ? {2'b0, mag_v} : {20'b0, d_reg.h - 20'd1};
    assign den_u = d_reg.sw;
    assign den_v = d_reg.sh;
    assign diff_u = $signed({1'b0, d_reg.ue}) - $signed({1'b0, d_reg.us});
    assign diff_v = $signed({1'b0, d_reg.ve}) - $signed({1'b0, d_reg.vs});

    assign u1_sum = $signed({3'b0, d_reg.us}) +
                    (prod_u_reg[37] ? -$signed({2'b0, quo_u[16:0]})
                                    : $signed({2'b0, quo_u[16:0]}));
    assign v1_sum = $signed({3'b0, d_reg.vs}) +
                    (prod_v_reg[37] ? -$signed({2'b0, quo_v[16:0]})
                                    : $signed({2'b0, quo_v[16:0]}));

    always_ff @(posedge aclk) begin
        if (accept) begin
            d_reg.x  <= s_rect_x;
            d_reg.y  <= s_rect_y;
            d_reg.w  <= s_rect_w;
            d_reg.h  <= s_rect_h;
            d_reg.sw <= s_tile_w;
            d_reg.sh <= s_tile_h;
            d_reg.us <= s_u_start;
            d_reg.vs <= s_v_start;
            d_reg.ue <= s_u_end;
            d_reg.ve <= s_v_end;
        end
        if (state_reg == F_MOD_WAIT && done_u && done_v) begin
            prod_u_reg <= $signed({1'b0, rem_u + 20'd1}) * diff_u;
            prod_v_reg <= $signed({1'b0, rem_v + 20'd1}) * diff_v;
        end
        if (state_reg == F_TEX_WAIT && done_u && done_v) begin
            d_reg.u1c <= u1_sum[17:0];
            d_reg.v1c <= v1_sum[17:0];
        end
    end

    tqg_div u_div_u (
        .aclk(aclk), .aresetn(aresetn), .start(start_mod || start_tex),
        .num(num_u), .den(den_u), .done(done_u), .quo(quo_u), .rem(rem_u)
    );

    tqg_div u_div_v (
        .aclk(aclk), .aresetn(aresetn), .start(start_mod || start_tex),
        .num(num_v), .den(den_v), .done(done_v), .quo(quo_v), .rem(rem_v)
    );

    assign q_data = d_reg;
endmodule
`default_nettype wire

FILE: design/tqg_queue.sv
// Two-entry descriptor queue between the front end and the tile walker.
// Depends on tqg_pkg for the descriptor and status types.
`default_nettype none
module tqg_queue (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             push,
    input  wire tqg_pkg::desc_t   wr_data,
    input  wire logic             pop,
    output tqg_pkg::desc_t        rd_data,
    output tqg_pkg::q_stat_t      stat
);
    import tqg_pkg::*;

    desc_t      mem_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] count_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push) begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 2'd1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

    assign rd_data    = mem_reg[rd_ptr_reg];
    assign stat.full  = count_reg == 2'd2;
    assign stat.empty = count_reg == 2'd0;
endmodule
`default_nettype wire

FILE: design/tqg_back.sv
// Tile walker: steps through columns and rows, converts corners to device
// coordinates and holds the result beat. Depends on tqg_pkg, tqg_div, macros.
`default_nettype none
`include "tiled_rect_quad_generator_macros.svh"
module tqg_back (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire tqg_pkg::q_stat_t q_stat,
    input  wire tqg_pkg::desc_t   q_data,
    output logic                  q_pop,
    input  wire logic [15:0]      half_width,
    input  wire logic [15:0]      half_height,
    input  wire logic [31:0]      tint,
    output logic                  m_valid,
    input  wire logic             m_ready,
    output logic signed [17:0]    m_quad_x0,
    output logic signed [17:0]    m_quad_y0,
    output logic signed [17:0]    m_quad_x1,
    output logic signed [17:0]    m_quad_y1,
    output logic [15:0]           m_tex_u0,
    output logic [15:0]           m_tex_v0,
    output logic signed [17:0]    m_tex_u1,
    output logic signed [17:0]    m_tex_v1,
    output logic [31:0]           m_quad_tint,
    output logic                  m_last_tile,
    output logic                  m_truncated
);
    import tqg_pkg::*;

    back_state_t        state_reg, state_next;
    desc_t              d_reg;
    logic signed [21:0] px_reg, py_reg;
    logic [19:0]        rw_reg, rh_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic               lc_reg, lr_reg;
    logic [3:0]         neg_reg;
    logic               out_valid_reg;
    logic               start, emit, tile_last, div_done_all;
    logic               lc, lr;
    logic [19:0]        tw, th;
    logic signed [21:0] px1, py1;
    logic [40:0]        nx0, nx1, ny0, ny1;
    logic [19:0]        den_x, den_y;
    logic [3:0]         done;
    logic [39:0]        q0, q1, q2, q3;
    logic [19:0]        r0, r1, r2, r3;

    logic signed [17:0] x0_reg, y0_reg, x1_reg, y1_reg, u1_reg, v1_reg;
    logic [15:0]        u0_reg, v0_reg;
    logic [31:0]        tint_reg;
    logic               last_reg, trunc_reg;

    assign lc  = rw_reg <= d_reg.sw;
    assign lr  = rh_reg <= d_reg.sh;
    assign tw  = lc ? rw_reg : d_reg.sw;
    assign th  = lr ? rh_reg : d_reg.sh;
    assign px1 = px_reg + $signed({2'b0, tw});
    assign py1 = py_reg + $signed({2'b0, th});
    assign nx0 = ndc_num(px_reg, half_width);
    assign nx1 = ndc_num(px1, half_width);
    assign ny0 = ndc_num(py_reg, half_height);
    assign ny1 = ndc_num(py1, half_height);
    assign den_x = half_den(half_width);
    assign den_y = half_den(half_height);
    assign div_done_all = &done;
    assign tile_last = (lc_reg && lr_reg) || (cnt_reg == CNT_W'(MAX_TILES - 1));

    always_comb begin
        state_next = state_reg;
        q_pop      = 1'b0;
        start      = 1'b0;
        emit       = 1'b0;
        case (state_reg)
            B_IDLE: begin
                if (!q_stat.empty) begin
                    q_pop      = 1'b1;
                    state_next = B_GO;
                end
            end
            B_GO: begin
                start      = 1'b1;
                state_next = B_WAIT;
            end
            B_WAIT: begin
                if (div_done_all) begin
                    state_next = B_EMIT;
                end
            end
            B_EMIT: begin
                if (!out_valid_reg || m_ready) begin
                    emit       = 1'b1;
                    state_next = tile_last ? B_IDLE : B_GO;
                end
            end
            default: state_next = B_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= B_IDLE;
            out_valid_reg <= 1'b0;
            cnt_reg       <= '0;
        end else begin
            state_reg <= state_next;
            if (emit) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
            if (q_pop) begin
                cnt_reg <= '0;
            end else if (emit) begin
                cnt_reg <= cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            d_reg  <= q_data;
            px_reg <= {{2{q_data.x[19]}}, q_data.x};
            py_reg <= {{2{q_data.y[19]}}, q_data.y};
            rw_reg <= q_data.w;
            rh_reg <= q_data.h;
        end
        if (start) begin
            lc_reg  <= lc;
            lr_reg  <= lr;
            neg_reg <= {ny1[40], nx1[40], ny0[40], nx0[40]};
        end
        if (emit) begin
            if (lr_reg) begin
                px_reg <= px_reg + $signed({2'b0, d_reg.sw});
                rw_reg <= rw_reg - d_reg.sw;
                py_reg <= {{2{d_reg.y[19]}}, d_reg.y};
                rh_reg <= d_reg.h;
            end else begin
                py_reg <= py_reg + $signed({2'b0, d_reg.sh});
                rh_reg <= rh_reg - d_reg.sh;
            end
            x0_reg    <= ndc_fix(neg_reg[0], q0, r0 != 20'd0);
            y0_reg    <= ndc_fix(neg_reg[1], q1, r1 != 20'd0);
            x1_reg    <= ndc_fix(neg_reg[2], q2, r2 != 20'd0);
            y1_reg    <= ndc_fix(neg_reg[3], q3, r3 != 20'd0);
            u0_reg    <= d_reg.us;
            v0_reg    <= d_reg.vs;
            u1_reg    <= lc_reg ? d_reg.u1c : {2'b0, d_reg.ue};
            v1_reg    <= lr_reg ? d_reg.v1c : {2'b0, d_reg.ve};
            tint_reg  <= tint;
            last_reg  <= tile_last;
            trunc_reg <= tile_last && !(lc_reg && lr_reg);
        end
    end

    tqg_div u_div_x0 (
        .aclk(aclk), .aresetn(aresetn), .start(start), .num(nx0[39:0]),
        .den(den_x), .done(done[0]), .quo(q0), .rem(r0)
    );
    tqg_div u_div_y0 (
        .aclk(aclk), .aresetn(aresetn), .start(start), .num(ny0[39:0]),
        .den(den_y), .done(done[1]), .quo(q1), .rem(r1)
    );
    tqg_div u_div_x1 (
        .aclk(aclk), .aresetn(aresetn), .start(start), .num(nx1[39:0]),
        .den(den_x), .done(done[2]), .quo(q2), .rem(r2)
    );
    tqg_div u_div_y1 (
        .aclk(aclk), .aresetn(aresetn), .start(start), .num(ny1[39:0]),
        .den(den_y), .done(done[3]), .quo(q3), .rem(r3)
    );

    assign m_valid     = out_valid_reg;
    assign m_quad_x0   = x0_reg;
    assign m_quad_y0   = y0_reg;
    assign m_quad_x1   = x1_reg;
    assign m_quad_y1   = y1_reg;
    assign m_tex_u0    = u0_reg;
    assign m_tex_v0    = v0_reg;
    assign m_tex_u1    = u1_reg;
    assign m_tex_v1    = v1_reg;
    assign m_quad_tint = tint_reg;
    assign m_last_tile = last_reg;
    assign m_truncated = trunc_reg;

    `TQG_ASSERT_IMPL(a_trunc_on_last, out_valid_reg && trunc_reg, last_reg)
    `TQG_ASSERT_IMPL(a_pop_not_empty, q_pop, !q_stat.empty)
    `TQG_ASSERT_NEXT(a_go_to_wait, state_reg == B_GO, state_reg == B_WAIT)
    `TQG_ASSERT_NEXT(a_done_to_emit, state_reg == B_WAIT && div_done_all, state_reg == B_EMIT)
endmodule
`default_nettype wire
